### hw/rtl/bbb_pkg.sv
// Package for the bounded box bounce step: types, codes and per-stage math helpers.
package bbb_pkg;

   localparam int unsigned SQRT_STEPS = 16;   // one root bit per stage
   localparam int unsigned QUO_W      = 15;   // quotient bits, magnitude <= 16384

   typedef enum logic [2:0] {
      WALL_NONE   = 3'd0,
      WALL_LEFT   = 3'd1,
      WALL_RIGHT  = 3'd2,
      WALL_TOP    = 3'd3,
      WALL_BOTTOM = 3'd4
   } wall_type;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      wall_type           wall;
   } body_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [16:0]        den;   // twice the root
      logic [2:0][30:0]   rem;
      logic [2:0][14:0]   quo;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [15:0] negate_dir(input logic signed [15:0] d);
      if (d == -16'sd32768) begin
         return 16'sd32767;
      end else begin
         return -d;
      end
   endfunction

   // magnitude of a Q2.14 component; -32768 maps to 32768
   function automatic logic [15:0] dir_mag(input logic signed [15:0] d);
      if (d[15]) begin
         return ~d + 16'd1;
      end else begin
         return d;
      end
   endfunction

   // one step of the digit-by-digit integer square root
   function automatic sqrt_type sqrt_step(input sqrt_type a, input int unsigned step);
      logic [31:0] bit_v;
      logic [32:0] trial;
      sqrt_type    o;
      bit_v = 32'd1 << (30 - 2 * step);
      trial = {1'b0, a.root} + {1'b0, bit_v};
      if ({1'b0, a.rem} >= trial) begin
         o.rem  = a.rem - trial[31:0];
         o.root = (a.root >> 1) + bit_v;
      end else begin
         o.rem  = a.rem;
         o.root = a.root >> 1;
      end
      return o;
   endfunction

   // one restoring-division bit for all three components
   function automatic div_type div_step(input div_type a, input int unsigned k);
      logic [47:0] trial;
      div_type     o;
      o     = a;
      trial = 48'(a.den) << k;
      for (int c = 0; c < 3; c++) begin
         if (48'(a.rem[c]) >= trial) begin
            o.rem[c]    = a.rem[c] - trial[30:0];
            o.quo[c][k] = 1'b1;
         end
      end
      return o;
   endfunction

endpackage

### hw/rtl/bounded_box_bounce_step_core.sv
// Top level: pipelined bounce step with wall clamp and direction normalize.
// Throughput: one item per cycle; the multiply, wall, 16-step root and 15-step
// divide stages all run as a straight pipeline, so busy is low outside reset.
// Reset: synchronous, clears valid bits and the scene registers to zero.
// The receiver cannot stall; rsp_valid marks each result for one cycle.
module bounded_box_bounce_step_core (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_dir_z,
   input  logic        [31:0] req_speed,
   input  logic        [31:0] req_box_width,
   input  logic        [31:0] req_box_height,
   input  logic        [15:0] req_frame_time,
   // response
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_pos_z,
   output logic signed [15:0] rsp_new_dir_x,
   output logic signed [15:0] rsp_new_dir_y,
   output logic signed [15:0] rsp_new_dir_z,
   output logic        [2:0]  rsp_wall_hit,
   // config
   input  logic               csr_write_enable,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_write_data
);

   localparam int unsigned NS = bbb_pkg::SQRT_STEPS;
   localparam int unsigned NQ = bbb_pkg::QUO_W;

   // ---------------- scene registers ----------------
   logic signed [31:0] cfg_center_x_ff, cfg_center_y_ff;
   logic        [31:0] cfg_width_ff, cfg_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_center_x_ff <= '0;
         cfg_center_y_ff <= '0;
         cfg_width_ff    <= '0;
         cfg_height_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (bbb_pkg::csr_index_type'(csr_index))
            bbb_pkg::CSR_CENTER_X: cfg_center_x_ff <= csr_write_data;
            bbb_pkg::CSR_CENTER_Y: cfg_center_y_ff <= csr_write_data;
            bbb_pkg::CSR_WIDTH:    cfg_width_ff    <= csr_write_data;
            bbb_pkg::CSR_HEIGHT:   cfg_height_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // every cycle takes a transfer once out of reset
   assign busy = reset;
   logic take;
   assign take = start & ~busy;

   // scene bounds, exact in 36 bits
   logic signed [35:0] bnd_left, bnd_right, bnd_top, bnd_bottom;
   always_comb begin
      bnd_left   = 36'(cfg_center_x_ff) - $signed({5'b0, cfg_width_ff[31:1]});
      bnd_right  = 36'(cfg_center_x_ff) + $signed({5'b0, cfg_width_ff[31:1]});
      bnd_top    = 36'(cfg_center_y_ff) + $signed({5'b0, cfg_height_ff[31:1]});
      bnd_bottom = 36'(cfg_center_y_ff) - $signed({5'b0, cfg_height_ff[31:1]});
   end

   // ---------------- stage 1: |dir| * speed ----------------
   logic               s1_vld_ff;
   logic signed [31:0] s1_pos_ff  [0:2];
   logic signed [15:0] s1_dir_ff  [0:2];
   logic        [47:0] s1_prod_ff [0:2];
   logic        [47:0] s1_prod_in [0:2];
   logic        [15:0] s1_dt_ff;
   logic        [30:0] s1_hbw_ff, s1_hbh_ff;

   always_comb begin
      s1_prod_in[0] = 48'(bbb_pkg::dir_mag(req_dir_x)) * 48'(req_speed);
      s1_prod_in[1] = 48'(bbb_pkg::dir_mag(req_dir_y)) * 48'(req_speed);
      s1_prod_in[2] = 48'(bbb_pkg::dir_mag(req_dir_z)) * 48'(req_speed);
   end

   always_ff @(posedge clock) begin
      s1_pos_ff[0] <= req_pos_x;
      s1_pos_ff[1] <= req_pos_y;
      s1_pos_ff[2] <= req_pos_z;
      s1_dir_ff[0] <= req_dir_x;
      s1_dir_ff[1] <= req_dir_y;
      s1_dir_ff[2] <= req_dir_z;
      s1_prod_ff   <= s1_prod_in;
      s1_dt_ff     <= req_frame_time;
      s1_hbw_ff    <= req_box_width[31:1];
      s1_hbh_ff    <= req_box_height[31:1];
   end

   // ---------------- stage 2: * frame time ----------------
   logic               s2_vld_ff;
   logic signed [31:0] s2_pos_ff  [0:2];
   logic signed [15:0] s2_dir_ff  [0:2];
   logic        [63:0] s2_prod_ff [0:2];
   logic        [63:0] s2_prod_in [0:2];
   logic        [30:0] s2_hbw_ff, s2_hbh_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s2_prod_in[a] = 64'(s1_prod_ff[a]) * 64'(s1_dt_ff);
      end
   end

   always_ff @(posedge clock) begin
      s2_pos_ff  <= s1_pos_ff;
      s2_dir_ff  <= s1_dir_ff;
      s2_prod_ff <= s2_prod_in;
      s2_hbw_ff  <= s1_hbw_ff;
      s2_hbh_ff  <= s1_hbh_ff;
   end

   // ---------------- stage 3: add displacement, saturate ----------------
   logic               s3_vld_ff;
   logic signed [31:0] s3_pos_ff [0:2];
   logic signed [31:0] s3_pos_in [0:2];
   logic signed [15:0] s3_dir_ff [0:2];
   logic        [30:0] s3_hbw_ff, s3_hbh_ff;

   always_comb begin
      logic signed [35:0] disp;
      for (int a = 0; a < 3; a++) begin
         // drop 30 fraction bits, truncating the magnitude
         disp = $signed({2'b00, s2_prod_ff[a][63:30]});
         if (s2_dir_ff[a][15]) begin
            disp = -disp;
         end
         s3_pos_in[a] = bbb_pkg::sat32(36'(s2_pos_ff[a]) + disp);
      end
   end

   always_ff @(posedge clock) begin
      s3_pos_ff <= s3_pos_in;
      s3_dir_ff <= s2_dir_ff;
      s3_hbw_ff <= s2_hbw_ff;
      s3_hbh_ff <= s2_hbh_ff;
   end

   // ---------------- stage 4: wall tests, first hit wins ----------------
   logic              s4_vld_ff;
   bbb_pkg::body_type s4_body_ff, s4_body_in;

   always_comb begin
      logic signed [35:0] px, py, hbw, hbh;
      px  = 36'(s3_pos_ff[0]);
      py  = 36'(s3_pos_ff[1]);
      hbw = $signed({5'b0, s3_hbw_ff});
      hbh = $signed({5'b0, s3_hbh_ff});
      s4_body_in.pos_x = s3_pos_ff[0];
      s4_body_in.pos_y = s3_pos_ff[1];
      s4_body_in.pos_z = s3_pos_ff[2];
      s4_body_in.dir_x = s3_dir_ff[0];
      s4_body_in.dir_y = s3_dir_ff[1];
      s4_body_in.dir_z = s3_dir_ff[2];
      s4_body_in.wall  = bbb_pkg::WALL_NONE;
      if (px - hbw < bnd_left) begin
         s4_body_in.pos_x = bbb_pkg::sat32(bnd_left + hbw);
         s4_body_in.dir_x = bbb_pkg::negate_dir(s3_dir_ff[0]);
         s4_body_in.wall  = bbb_pkg::WALL_LEFT;
      end else if (px + hbw > bnd_right) begin
         s4_body_in.pos_x = bbb_pkg::sat32(bnd_right - hbw);
         s4_body_in.dir_x = bbb_pkg::negate_dir(s3_dir_ff[0]);
         s4_body_in.wall  = bbb_pkg::WALL_RIGHT;
      end else if (py + hbh > bnd_top) begin
         s4_body_in.pos_y = bbb_pkg::sat32(bnd_top - hbh);
         s4_body_in.dir_y = bbb_pkg::negate_dir(s3_dir_ff[1]);
         s4_body_in.wall  = bbb_pkg::WALL_TOP;
      end else if (py - hbh < bnd_bottom) begin
         s4_body_in.pos_y = bbb_pkg::sat32(bnd_bottom + hbh);
         s4_body_in.dir_y = bbb_pkg::negate_dir(s3_dir_ff[1]);
         s4_body_in.wall  = bbb_pkg::WALL_BOTTOM;
      end
   end

   always_ff @(posedge clock) begin
      s4_body_ff <= s4_body_in;
   end

   // ---------------- sum of squares + root pipeline ----------------
   // entry 0 holds the squared length, entries 1..NS one root bit each
   logic              sq_vld_ff  [0:NS];
   bbb_pkg::sqrt_type sq_ff      [0:NS];
   bbb_pkg::sqrt_type sq_in      [0:NS];
   bbb_pkg::body_type sq_body_ff [0:NS];

   always_comb begin
      logic signed [31:0] sx, sy, sz;
      sx = 32'(s4_body_ff.dir_x) * 32'(s4_body_ff.dir_x);
      sy = 32'(s4_body_ff.dir_y) * 32'(s4_body_ff.dir_y);
      sz = 32'(s4_body_ff.dir_z) * 32'(s4_body_ff.dir_z);
      sq_in[0].rem  = $unsigned(sx) + $unsigned(sy) + $unsigned(sz);
      sq_in[0].root = '0;
      for (int i = 1; i <= NS; i++) begin
         sq_in[i] = bbb_pkg::sqrt_step(sq_ff[i-1], i - 1);
      end
   end

   always_ff @(posedge clock) begin
      sq_ff         <= sq_in;
      sq_body_ff[0] <= s4_body_ff;
      for (int i = 1; i <= NS; i++) begin
         sq_body_ff[i] <= sq_body_ff[i-1];
      end
   end

   // ---------------- divide pipeline ----------------
   // entry 0 loads |d| * 32768 + len over 2 * len, one quotient bit per entry after
   logic              dv_vld_ff  [0:NQ];
   bbb_pkg::div_type  dv_ff      [0:NQ];
   bbb_pkg::div_type  dv_in      [0:NQ];
   bbb_pkg::body_type dv_body_ff [0:NQ];

   always_comb begin
      logic [15:0] len;
      len           = sq_ff[NS].root[15:0];
      dv_in[0].den  = {len, 1'b0};
      dv_in[0].quo  = '0;
      dv_in[0].rem[0] = {bbb_pkg::dir_mag(sq_body_ff[NS].dir_x), 15'b0} + 31'(len);
      dv_in[0].rem[1] = {bbb_pkg::dir_mag(sq_body_ff[NS].dir_y), 15'b0} + 31'(len);
      dv_in[0].rem[2] = {bbb_pkg::dir_mag(sq_body_ff[NS].dir_z), 15'b0} + 31'(len);
      for (int i = 1; i <= NQ; i++) begin
         dv_in[i] = bbb_pkg::div_step(dv_ff[i-1], NQ - i);
      end
   end

   always_ff @(posedge clock) begin
      dv_ff         <= dv_in;
      dv_body_ff[0] <= sq_body_ff[NS];
      for (int i = 1; i <= NQ; i++) begin
         dv_body_ff[i] <= dv_body_ff[i-1];
      end
   end

   // ---------------- valid chain ----------------
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         sq_vld_ff    <= '{default: 1'b0};
         dv_vld_ff    <= '{default: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= take;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         sq_vld_ff[0] <= s4_vld_ff;
         for (int i = 1; i <= NS; i++) begin
            sq_vld_ff[i] <= sq_vld_ff[i-1];
         end
         dv_vld_ff[0] <= sq_vld_ff[NS];
         for (int i = 1; i <= NQ; i++) begin
            dv_vld_ff[i] <= dv_vld_ff[i-1];
         end
         rsp_valid_ff <= dv_vld_ff[NQ];
      end
   end

   // ---------------- output register ----------------
   logic signed [31:0] rsp_pos_ff [0:2];
   logic signed [15:0] rsp_dir_ff [0:2];
   logic signed [15:0] rsp_dir_in [0:2];
   logic        [2:0]  rsp_wall_ff;
   logic signed [15:0] out_dir    [0:2];

   always_comb begin
      out_dir[0] = dv_body_ff[NQ].dir_x;
      out_dir[1] = dv_body_ff[NQ].dir_y;
      out_dir[2] = dv_body_ff[NQ].dir_z;
      for (int c = 0; c < 3; c++) begin
         if (dv_ff[NQ].den == '0) begin
            rsp_dir_in[c] = out_dir[c];          // zero vector passes through
         end else if (out_dir[c][15]) begin
            rsp_dir_in[c] = -$signed({1'b0, dv_ff[NQ].quo[c]});
         end else begin
            rsp_dir_in[c] = $signed({1'b0, dv_ff[NQ].quo[c]});
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff[0] <= dv_body_ff[NQ].pos_x;
      rsp_pos_ff[1] <= dv_body_ff[NQ].pos_y;
      rsp_pos_ff[2] <= dv_body_ff[NQ].pos_z;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_wall_ff   <= dv_body_ff[NQ].wall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_pos_x = rsp_pos_ff[0];
   assign rsp_new_pos_y = rsp_pos_ff[1];
   assign rsp_new_pos_z = rsp_pos_ff[2];
   assign rsp_new_dir_x = rsp_dir_ff[0];
   assign rsp_new_dir_y = rsp_dir_ff[1];
   assign rsp_new_dir_z = rsp_dir_ff[2];
   assign rsp_wall_hit  = rsp_wall_ff;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##38 rsp_valid)
      else $error("transfer did not produce a result after 38 cycles");

   a_unit_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_dir_x <= 16'sd16384 && rsp_new_dir_x >= -16'sd16384 &&
                     rsp_new_dir_y <= 16'sd16384 && rsp_new_dir_y >= -16'sd16384 &&
                     rsp_new_dir_z <= 16'sd16384 && rsp_new_dir_z >= -16'sd16384))
      else $error("normalized component out of range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

### dv/tb_top.sv
// Testbench for the bounce step core: random and directed bodies checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

   // one body as presented on the request ports
   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] dx, dy, dz;
      logic [31:0] spd, bw, bh;
      logic [15:0] dt;
   } body_in_type;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] dx, dy, dz;
      logic [2:0] wall;
   } body_out_type;

   // scoreboard: scene copy, bounce predictor, queue of expected bodies
   class bounce_board;
      logic signed [31:0] cx, cy;
      logic [31:0] sw, sh;
      body_out_type expected_bodies[$];
      int errors;
      int checked;
      int hits[5];

      function new();
         cx = 0; cy = 0; sw = 0; sh = 0; errors = 0; checked = 0;
         foreach (hits[i]) hits[i] = 0;
      endfunction

      function void write_scene(bbb_pkg::csr_index_type idx, logic [31:0] v);
         case (idx)
            bbb_pkg::CSR_CENTER_X: cx = v;
            bbb_pkg::CSR_CENTER_Y: cy = v;
            bbb_pkg::CSR_WIDTH:    sw = v;
            bbb_pkg::CSR_HEIGHT:   sh = v;
         endcase
      endfunction

      static function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      static function longint move_by(longint d, longint spd, longint dt);
         longint m;
         logic [79:0] p;
         m = (d < 0) ? -d : d;
         p = 80'(m) * 80'(spd) * 80'(dt);
         p = p >> 30;
         return (d < 0) ? -longint'(p) : longint'(p);
      endfunction

      static function longint flip(longint d);
         return (d == -32768) ? 32767 : -d;
      endfunction

      static function longint unit_comp(longint d, longint len);
         longint m, q;
         m = (d < 0) ? -d : d;
         q = (m * 32768 + len) / (2 * len);
         return (d < 0) ? -q : q;
      endfunction

      static function longint root_floor(longint s);
         longint r;
         r = 0;
         while ((r + 1) * (r + 1) <= s) r++;
         return r;
      endfunction

      function void note_body(body_in_type b);
         longint x, y, z, dx, dy, dz, hbw, hbh, lft, rgt, tp, bt, s, len;
         body_out_type e;
         bbb_pkg::wall_type w;
         dx = b.dx; dy = b.dy; dz = b.dz;
         hbw = longint'(b.bw >> 1); hbh = longint'(b.bh >> 1);
         lft = longint'(cx) - longint'(sw >> 1); rgt = longint'(cx) + longint'(sw >> 1);
         tp = longint'(cy) + longint'(sh >> 1); bt = longint'(cy) - longint'(sh >> 1);
         x = clip32(longint'(b.px) + move_by(dx, b.spd, b.dt));
         y = clip32(longint'(b.py) + move_by(dy, b.spd, b.dt));
         z = clip32(longint'(b.pz) + move_by(dz, b.spd, b.dt));
         w = bbb_pkg::WALL_NONE;
         if (x - hbw < lft) begin
            x = clip32(lft + hbw); dx = flip(dx); w = bbb_pkg::WALL_LEFT;
         end else if (x + hbw > rgt) begin
            x = clip32(rgt - hbw); dx = flip(dx); w = bbb_pkg::WALL_RIGHT;
         end else if (y + hbh > tp) begin
            y = clip32(tp - hbh); dy = flip(dy); w = bbb_pkg::WALL_TOP;
         end else if (y - hbh < bt) begin
            y = clip32(bt + hbh); dy = flip(dy); w = bbb_pkg::WALL_BOTTOM;
         end
         s = dx * dx + dy * dy + dz * dz;
         if (s != 0) begin
            len = root_floor(s);
            dx = unit_comp(dx, len); dy = unit_comp(dy, len); dz = unit_comp(dz, len);
         end
         e.px = x[31:0]; e.py = y[31:0]; e.pz = z[31:0];
         e.dx = dx[15:0]; e.dy = dy[15:0]; e.dz = dz[15:0];
         e.wall = w;
         hits[w]++;
         expected_bodies.push_back(e);
      endfunction

      function void check_body(body_out_type a);
         body_out_type e;
         if (expected_bodies.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
         end
         e = expected_bodies.pop_front();
         checked++;
         if (a.px !== e.px) begin
            $error("new_pos_x exp %0d got %0d", e.px, a.px); errors++;
         end
         if (a.py !== e.py) begin
            $error("new_pos_y exp %0d got %0d", e.py, a.py); errors++;
         end
         if (a.pz !== e.pz) begin
            $error("new_pos_z exp %0d got %0d", e.pz, a.pz); errors++;
         end
         if (a.dx !== e.dx) begin
            $error("new_dir_x exp %0d got %0d", e.dx, a.dx); errors++;
         end
         if (a.dy !== e.dy) begin
            $error("new_dir_y exp %0d got %0d", e.dy, a.dy); errors++;
         end
         if (a.dz !== e.dz) begin
            $error("new_dir_z exp %0d got %0d", e.dz, a.dz); errors++;
         end
         if (a.wall !== e.wall) begin
            $error("wall_hit exp %0d got %0d", e.wall, a.wall); errors++;
         end
      endfunction
   endclass

   localparam int LATENCY = 38;
   localparam longint CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [31:0] req_speed = '0, req_box_width = '0, req_box_height = '0;
   logic [15:0] req_frame_time = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z;
   logic signed [15:0] rsp_new_dir_x, rsp_new_dir_y, rsp_new_dir_z;
   logic [2:0] rsp_wall_hit;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_write_data = '0;

   bounce_board board = new();
   longint cycles = 0;
   int sent = 0;

   always #5 clock = ~clock;

   bounded_box_bounce_step_core i_dut (.*);

   // result side: the block strobes each result for one cycle
   always @(posedge clock) begin
      body_out_type a;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         a.px = rsp_new_pos_x; a.py = rsp_new_pos_y; a.pz = rsp_new_pos_z;
         a.dx = rsp_new_dir_x; a.dy = rsp_new_dir_y; a.dz = rsp_new_dir_z;
         a.wall = rsp_wall_hit;
         board.check_body(a);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one, often none; start drops only for a gap
   task automatic idle_gap();
      int n;
      n = 0;
      if ($urandom_range(0, 1) != 0 && $urandom_range(0, 2) != 0) begin
         n = ($urandom_range(0, 15) == 0) ? int'($urandom_range(10, 60))
                                          : int'($urandom_range(1, 3));
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // single transfer: raise start, hold until busy is low at an edge
   task automatic send_body(body_in_type b);
      start <= 1'b1;
      req_pos_x <= b.px; req_pos_y <= b.py; req_pos_z <= b.pz;
      req_dir_x <= b.dx; req_dir_y <= b.dy; req_dir_z <= b.dz;
      req_speed <= b.spd; req_box_width <= b.bw; req_box_height <= b.bh;
      req_frame_time <= b.dt;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_body(b);
      sent++;
      idle_gap();
   endtask

   // drain: wait for every expectation, then idle on so that a stray result is caught
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.expected_bodies.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(bbb_pkg::csr_index_type idx, logic [31:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      board.write_scene(idx, v);
   endtask

   task automatic set_scene(logic [31:0] x, logic [31:0] y, logic [31:0] w, logic [31:0] h);
      write_csr(bbb_pkg::CSR_CENTER_X, x);
      write_csr(bbb_pkg::CSR_CENTER_Y, y);
      write_csr(bbb_pkg::CSR_WIDTH, w);
      write_csr(bbb_pkg::CSR_HEIGHT, h);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] rand_dir();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // bodies near the scene, box and speed small enough for all outcomes; wild ones are fully random
   function automatic body_in_type rand_body(bit wild);
      body_in_type b;
      b.dx = rand_dir(); b.dy = rand_dir(); b.dz = rand_dir();
      if (wild) begin
         b.px = $urandom; b.py = $urandom; b.pz = $urandom;
         b.spd = $urandom; b.bw = $urandom; b.bh = $urandom; b.dt = 16'($urandom);
      end else begin
         b.px = board.cx + $signed($urandom_range(0, 32'h00C0_0000)) - 32'sh0060_0000;
         b.py = board.cy + $signed($urandom_range(0, 32'h00C0_0000)) - 32'sh0060_0000;
         b.pz = $urandom;
         b.spd = $urandom_range(0, 32'h0040_0000);
         b.bw = $urandom_range(0, 32'h0020_0000);
         b.bh = $urandom_range(0, 32'h0020_0000);
         b.dt = 16'($urandom);
      end
      return b;
   endfunction

   function automatic body_in_type make_body(logic [31:0] px, logic [31:0] py, logic [15:0] dx,
                                             logic [15:0] dy, logic [31:0] spd, logic [15:0] dt);
      body_in_type b;
      b.px = px; b.py = py; b.pz = 32'h7FFF_0000;
      b.dx = dx; b.dy = dy; b.dz = 16'h4000;
      b.spd = spd; b.bw = 32'h0002_0000; b.bh = 32'h0002_0000; b.dt = dt;
      return b;
   endfunction

   initial begin
      body_in_type b;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 20 x 20 scene at origin
      set_scene(32'h0, 32'h0, 32'h0014_0000, 32'h0014_0000);
      send_body(make_body(0, 0, 0, 0, 32'h0001_0000, 16'h8000));              // zero x and y dir
      send_body(make_body(32'hFFF8_0000, 0, 16'h8000, 0, 32'h000A_0000, 16'hFFFF)); // left, -32768
      send_body(make_body(32'h0008_0000, 0, 16'h7FFF, 0, 32'h000A_0000, 16'hFFFF)); // right
      send_body(make_body(0, 32'h0009_8000, 0, 16'h4000, 32'h0001_0000, 16'h8000)); // top
      send_body(make_body(0, 32'hFFF6_0000, 0, 16'h8000, 32'h0001_0000, 16'h8000)); // bottom
      send_body(make_body(32'hFFF8_0000, 32'h0009_8000, 16'hC000, 16'h4000,
                          32'h000A_0000, 16'hFFFF));                          // corner: left first
      send_body(make_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF,
                          32'hFFFF_FFFF, 16'hFFFF));                          // saturate high
      send_body(make_body(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
                          32'hFFFF_FFFF, 16'hFFFF));                          // saturate low
      send_body(make_body(0, 0, 16'h0001, 0, 0, 0));                         // tiny dir
      b = make_body(0, 0, 16'h1234, 16'hEDCB, 32'h0003_0000, 16'h1000);
      b.bw = 32'hFFFF_FFFF; b.bh = 32'hFFFF_FFFF;                            // box beyond scene
      send_body(b);
      drain();

      // extreme scenes: empty scene at the most negative center, then the widest
      set_scene(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      send_body(make_body(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h0001, 32'h1, 16'h1));
      send_body(make_body(32'h0, 32'h0, 16'h2000, 16'h2000, 32'h0001_0000, 16'h4000));
      drain();
      set_scene(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_body(make_body(32'h7FFF_FFFF, 32'h0, 16'h7FFF, 16'h7FFF, 32'h10_0000, 16'hFFFF));
      send_body(make_body(32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
                          32'h10_0000, 16'hFFFF));
      drain();

      // random phases over several scenes; a full drain between them
      for (int ph = 0; ph < 6; ph++) begin
         set_scene($urandom, $urandom, $urandom_range(0, 32'h00A0_0000),
                   $urandom_range(0, 32'h00A0_0000));
         for (int i = 0; i < 75; i++) send_body(rand_body($urandom_range(0, 9) == 0));
         drain();
      end

      $display("%0d bodies sent, %0d checked over 9 scene settings", sent, board.checked);
      $display("walls hit: none %0d left %0d right %0d top %0d bottom %0d",
               board.hits[0], board.hits[1], board.hits[2], board.hits[3], board.hits[4]);
      if (board.errors == 0 && board.expected_bodies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
